### hw/rtl/cba_pkg.sv
// Shared types and constants of the contiguous block allocator.
package cba_pkg;

  localparam int unsigned ModeW   = 2;
  localparam int unsigned SlotW   = 5;
  localparam int unsigned BlkW    = 8;
  localparam int unsigned StatusW = 3;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 32;

  typedef enum logic [ModeW-1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_COUNT = 2'd2,
    MODE_QUERY = 2'd3
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    STAT_PLACED = 3'd0,
    STAT_RETRY  = 3'd1,
    STAT_NOROOM = 3'd2,
    STAT_FREED  = 3'd3,
    STAT_EMPTY  = 3'd4,
    STAT_REPORT = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_SET,
    S_CLEAR,
    S_DONE,
    S_WIPE
  } state_e;

  typedef struct packed {
    logic            en;
    logic            used;
    logic [BlkW-1:0] start;
    logic [BlkW-1:0] len;
  } slot_wr_t;

  typedef struct packed {
    logic            used;
    logic [BlkW-1:0] start;
    logic [BlkW-1:0] len;
  } slot_rd_t;

endpackage

### hw/rtl/cba_slot_table.sv
// Slot table: start and length memory with a per-slot occupied flag.
module cba_slot_table #(
  parameter int unsigned SLOTS = 32,
  parameter int unsigned SW    = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [SW-1:0]     rd_idx_i,
  output cba_pkg::slot_rd_t rd_o,
  input  logic [SW-1:0]     wr_idx_i,
  input  cba_pkg::slot_wr_t wr_i
);
  import cba_pkg::*;

  logic [2*BlkW-1:0] mem_q [SLOTS];
  logic [SLOTS-1:0]  used_q;
  logic [2*BlkW-1:0] rd_data_q;
  logic              rd_used_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_i.used) begin
      mem_q[wr_idx_i] <= {wr_i.start, wr_i.len};
    end
    rd_data_q <= mem_q[rd_idx_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q    <= '0;
      rd_used_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        used_q[wr_idx_i] <= wr_i.used;
      end
      rd_used_q <= used_q[rd_idx_i];
    end
  end

  assign rd_o.used  = rd_used_q;
  assign rd_o.start = rd_data_q[2*BlkW-1:BlkW];
  assign rd_o.len   = rd_data_q[BlkW-1:0];

endmodule

### hw/rtl/contiguous_block_allocator.sv
// Top level of the contiguous block allocator with its block walk sequencer.
//
// The block keeps a busy bitmap of BLOCKS blocks numbered 1 to BLOCKS and a
// table of SLOTS file slots. Requests arrive on the s_axis channel, one item
// per request, and every request produces exactly one item on m_axis.
// Mode 0 places a run of run_length blocks at try_start into a slot, mode 1
// frees a slot, mode 2 reports the free count and mode 3 reports a slot.
// Count, query, rejected and out of range requests pass from the read state
// straight to the done state. An allocate that passes the range checks
// walks the run once to test each block, stopping with a retry at the first
// busy one, and once more to mark it, one bitmap bit per cycle through the
// shared block pointer and counter. A free walks the run once. The block
// takes a new item only when idle. The result sits in an output register;
// a new item is accepted while it waits, and the sequencer holds its
// finished result until the register drains. Reset frees all slots and
// sets the free count to BLOCKS; a clearing pass then empties the bitmap,
// and s_axis_tready stays low until it ends.
module contiguous_block_allocator #(
  parameter int unsigned BLOCKS = 128,
  parameter int unsigned SLOTS  = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // mode[1:0], slot[6:2], run_length[14:7], try_start[22:15], zero pad[23]
  input  logic [cba_pkg::InDataW-1:0]      s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // status[2:0], first_block[10:3], block_count[18:11], free_blocks[26:19],
  // zero pad[31:27]
  output logic [cba_pkg::OutDataW-1:0]     m_axis_tdata
);
  import cba_pkg::*;

  localparam int unsigned BW = $clog2(BLOCKS);
  localparam int unsigned SW = $clog2(SLOTS);

  state_e          state_q, state_d;
  mode_e           mode_q;
  logic [SlotW-1:0] slot_q;
  logic [BlkW-1:0] len_q, start_q;
  logic [BlkW-1:0] cur_q, cur_d;
  logic [BlkW-1:0] rem_q, rem_d;
  logic [BlkW-1:0] free_q, free_d;
  status_e         res_status_q, res_status_d;
  logic [BlkW-1:0] res_first_q, res_first_d;
  logic [BlkW-1:0] res_count_q, res_count_d;
  logic            busy_mem [BLOCKS];
  logic            busy_rd_q;
  logic            busy_we, busy_val;
  logic [BlkW-1:0] blk_m1;
  logic [BW-1:0]   blk_idx;
  logic [BlkW-1:0] rd_blk_m1;
  logic [BW-1:0]   rd_blk_idx;

  logic            out_valid_q;
  status_e         out_status_q;
  logic [BlkW-1:0] out_first_q, out_count_q, out_free_q;

  logic            in_acc, out_load;
  logic [SlotW-1:0] in_slot;
  logic [SW+SlotW-1:0] in_slot_ext, slot_ext;
  logic [SW-1:0]   rd_idx, slot_idx;
  logic            slot_ok;
  logic [BlkW:0]   run_end;
  slot_rd_t        slot_rd;
  slot_wr_t        slot_wr;

  assign in_slot     = s_axis_tdata[6:2];
  assign in_slot_ext = {{SW{1'b0}}, in_slot};
  assign slot_ext    = {{SW{1'b0}}, slot_q};
  assign slot_idx    = slot_ext[SW-1:0];
  assign rd_idx      = (state_q == S_IDLE) ? in_slot_ext[SW-1:0] : slot_idx;
  assign slot_ok     = ({4'd0, slot_q} < 9'(SLOTS));
  assign run_end     = {1'b0, start_q} + {1'b0, len_q} - 9'd1;
  assign blk_m1      = cur_q - 8'd1;
  assign blk_idx     = blk_m1[BW-1:0];
  assign rd_blk_m1   = cur_d - 8'd1;
  assign rd_blk_idx  = rd_blk_m1[BW-1:0];

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);

  cba_slot_table #(
    .SLOTS (SLOTS),
    .SW    (SW)
  ) u_slot_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_idx_i (rd_idx),
    .rd_o     (slot_rd),
    .wr_idx_i (slot_idx),
    .wr_i     (slot_wr)
  );

  always_comb begin
    state_d      = state_q;
    cur_d        = cur_q;
    rem_d        = rem_q;
    free_d       = free_q;
    res_status_d = res_status_q;
    res_first_d  = res_first_q;
    res_count_d  = res_count_q;
    busy_we      = 1'b0;
    busy_val     = 1'b0;
    slot_wr      = '0;
    case (state_q)
      S_WIPE: begin
        busy_we  = 1'b1;
        busy_val = 1'b0;
        cur_d    = cur_q - 8'd1;
        if (cur_q == 8'd1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        res_status_d = STAT_NOROOM;
        res_first_d  = '0;
        res_count_d  = '0;
        state_d      = S_DONE;
        case (mode_q)
          MODE_ALLOC: begin
            if (!slot_ok || slot_rd.used || len_q == '0 || len_q > free_q) begin
              res_status_d = STAT_NOROOM;
            end else if (start_q == '0 || run_end > 9'(BLOCKS)) begin
              res_status_d = STAT_RETRY;
            end else begin
              cur_d   = start_q;
              rem_d   = len_q;
              state_d = S_CHECK;
            end
          end
          MODE_FREE: begin
            if (!slot_ok || !slot_rd.used) begin
              res_status_d = STAT_EMPTY;
            end else begin
              cur_d   = slot_rd.start;
              rem_d   = slot_rd.len;
              state_d = S_CLEAR;
            end
          end
          MODE_COUNT: begin
            res_status_d = STAT_REPORT;
          end
          MODE_QUERY: begin
            if (!slot_ok || !slot_rd.used) begin
              res_status_d = STAT_EMPTY;
            end else begin
              res_status_d = STAT_REPORT;
              res_first_d  = slot_rd.start;
              res_count_d  = slot_rd.len;
            end
          end
          default: begin
            res_status_d = STAT_NOROOM;
          end
        endcase
      end
      S_CHECK: begin
        if (busy_rd_q) begin
          res_status_d = STAT_RETRY;
          state_d      = S_DONE;
        end else if (rem_q == 8'd1) begin
          cur_d   = start_q;
          rem_d   = len_q;
          state_d = S_SET;
        end else begin
          cur_d = cur_q + 8'd1;
          rem_d = rem_q - 8'd1;
        end
      end
      S_SET: begin
        busy_we  = 1'b1;
        busy_val = 1'b1;
        cur_d    = cur_q + 8'd1;
        rem_d    = rem_q - 8'd1;
        if (rem_q == 8'd1) begin
          slot_wr.en    = 1'b1;
          slot_wr.used  = 1'b1;
          slot_wr.start = start_q;
          slot_wr.len   = len_q;
          free_d        = free_q - len_q;
          res_status_d  = STAT_PLACED;
          res_first_d   = start_q;
          res_count_d   = len_q;
          state_d       = S_DONE;
        end
      end
      S_CLEAR: begin
        busy_we  = 1'b1;
        busy_val = 1'b0;
        cur_d    = cur_q + 8'd1;
        rem_d    = rem_q - 8'd1;
        if (rem_q == 8'd1) begin
          slot_wr.en   = 1'b1;
          slot_wr.used = 1'b0;
          free_d       = free_q + slot_rd.len;
          res_status_d = STAT_FREED;
          state_d      = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_WIPE;
      cur_q       <= 8'(BLOCKS);
      free_q      <= 8'(BLOCKS);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      free_q  <= free_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_we) begin
      busy_mem[blk_idx] <= busy_val;
    end
    busy_rd_q <= busy_mem[rd_blk_idx];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q  <= mode_e'(s_axis_tdata[1:0]);
      slot_q  <= in_slot;
      len_q   <= s_axis_tdata[14:7];
      start_q <= s_axis_tdata[22:15];
    end
    rem_q        <= rem_d;
    res_status_q <= res_status_d;
    res_first_q  <= res_first_d;
    res_count_q  <= res_count_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_first_q  <= res_first_q;
      out_count_q  <= res_count_q;
      out_free_q   <= free_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_free_q, out_count_q, out_first_q, out_status_q};

endmodule
